[rtl/core/cpba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared types and constants for the clustered page bitmap allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

  localparam int PAGES      = 1024;
  localparam int CHUNKS     = 4;
  localparam int PW         = $clog2(PAGES);
  localparam int CW         = $clog2(CHUNKS);
  localparam int CHUNK_SPAN = (PAGES + CHUNKS - 1) / CHUNKS;
  localparam int USERS_MAX  = 2047;
  localparam int WORD_BITS  = 32;
  localparam int WORDS      = PAGES / WORD_BITS;
  localparam int WW         = $clog2(WORD_BITS);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_NEXT,
    ST_MARK,
    ST_SPAN,
    ST_CHUNK,
    ST_OUT
  } state_t;

  // Candidate search windows, in chunked order.
  typedef enum logic [2:0] {
    SR_USED,
    SR_ACTIVE,
    SR_BELOW_ADJ,
    SR_ABOVE_ADJ,
    SR_BELOW,
    SR_ABOVE,
    SR_ALL
  } search_t;

  typedef struct packed {
    logic    start;      // latch the request
    logic    clr_start;  // begin sweep for clear/mark
    logic    scan_start; // begin scan of current window
    logic    span_start; // begin span recompute
    logic    mark;       // perform sweep step writing
    logic    scan;       // scan step
    logic    span;       // span step
    logic    chunk;      // update chunk state
    logic    load_out;   // capture result
    search_t win;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic scan_done;
    logic found;
    logic span_done;
    logic win_valid;
    logic alloc;
    logic fail_early;
  } sts_t;

  function automatic logic [PW:0] chunk_lo(input logic [CW:0] i);
    int v;
    v = int'(i) * CHUNK_SPAN;
    if (v > PAGES) v = PAGES;
    return (PW+1)'(v);
  endfunction

endpackage

[rtl/core/cpba_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_ctrl
// Sequencer for search, marking, span recompute and chunk update.
// ----------------------------------------------------------------------------
module cpba_ctrl
  import cpba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  input  logic mode,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t  state, state_next;
  search_t win, win_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      win   <= SR_USED;
    end else begin
      state <= state_next;
      win   <= win_next;
    end
  end

  always_comb begin
    state_next = state;
    win_next   = win;
    cmd        = '0;
    cmd.win    = win;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (!sts.alloc) begin
          cmd.clr_start = 1'b1;
          state_next = ST_MARK;
        end else if (sts.fail_early) begin
          state_next = ST_OUT;
        end else begin
          win_next = mode ? SR_USED : SR_ALL;
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.win_valid) begin
          cmd.scan_start = 1'b1;
          state_next = ST_SCAN;
        end else if (win == SR_ALL) begin
          state_next = ST_OUT;
        end else begin
          win_next = search_t'(win + 3'd1);
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          cmd.clr_start = 1'b1;
          state_next = ST_MARK;
        end else if (sts.scan_done) begin
          if (win == SR_ALL) state_next = ST_OUT;
          else begin
            win_next = search_t'(win + 3'd1);
            state_next = ST_NEXT;
          end
        end
      end
      ST_MARK: begin
        cmd.mark = 1'b1;
        if (sts.sweep_done) begin
          cmd.span_start = 1'b1;
          state_next = ST_SPAN;
        end
      end
      ST_SPAN: begin
        cmd.span = 1'b1;
        if (sts.span_done) state_next = ST_CHUNK;
      end
      ST_CHUNK: begin
        cmd.chunk = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/cpba_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_dp
// Page bitmap, span registers, chunk state and the one-page-a-cycle walker.
// ----------------------------------------------------------------------------
module cpba_dp
  import cpba_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          mode,
  input  logic          req_op,
  input  logic [PW-1:0] req_start,
  input  logic [PW:0]   req_count,
  input  cmd_t          cmd,
  output sts_t          sts,
  output logic          r_status,
  output logic [PW-1:0] r_page,
  output logic          r_any,
  output logic [CW-1:0] r_lo,
  output logic [CW-1:0] r_hi,
  output logic          r_changed
);

  // Bitmap as words of pages, cleared at reset.
  logic [WORD_BITS-1:0]   page_map [WORDS];
  logic [CHUNKS-1:0]      chunk_on;
  logic [10:0]            chunk_users [CHUNKS];
  logic [PW:0]            low_used;
  logic                   span_empty;
  logic [PW-1:0]          high_used;

  logic                   op;
  logic [PW:0]            cnt;
  logic [PW-1:0]          rel_start;
  logic [PW:0]            s_start, s_end;     // sweep range
  logic [PW:0]            ptr, w_end, run;
  logic [PW:0]            found_pos;
  logic                   ok;
  logic [PW:0]            n_low;
  logic [PW-1:0]          n_high;
  logic                   n_empty;
  logic [PW+1:0]          wsum, rsum;

  // Window selection
  logic [PW:0]  wlo, whi;
  logic         wexact, wok;
  logic [CW-1:0] a_lo, a_hi;
  logic         any_on;

  always_comb begin
    any_on = |chunk_on;
    a_lo = '0;
    a_hi = '0;
    for (int i = CHUNKS - 1; i >= 0; i--) if (chunk_on[i]) a_lo = CW'(i);
    for (int i = 0; i < CHUNKS; i++) if (chunk_on[i]) a_hi = CW'(i);
  end

  always_comb begin
    wlo = '0;
    whi = (PW+1)'(PAGES);
    wexact = 1'b0;
    wok = 1'b1;
    case (cmd.win)
      SR_USED: begin
        wok = mode && !span_empty;
        wlo = low_used;
        whi = {1'b0, high_used} + 1'b1;
      end
      SR_ACTIVE: begin
        wok = mode && !span_empty && any_on;
        wlo = chunk_lo({1'b0, a_lo});
        whi = chunk_lo({1'b0, a_hi} + 1'b1);
      end
      SR_BELOW_ADJ: begin
        wok = mode && !span_empty && (low_used >= cnt);
        wlo = low_used - cnt;
        whi = low_used;
        wexact = 1'b1;
      end
      SR_ABOVE_ADJ: begin
        wok = mode && !span_empty;
        wlo = {1'b0, high_used} + 1'b1;
        whi = (PW+1)'(PAGES);
        wexact = 1'b1;
      end
      SR_BELOW: begin
        wok = mode && !span_empty;
        wlo = '0;
        whi = low_used;
      end
      SR_ABOVE: begin
        wok = mode && !span_empty;
        wlo = {1'b0, high_used} + 1'b1;
        whi = (PW+1)'(PAGES);
      end
      SR_ALL: begin
        wok = 1'b1;
      end
      default: wok = 1'b0;
    endcase
  end

  assign wsum = {1'b0, wlo} + {1'b0, cnt};
  assign rsum = {2'b00, rel_start} + {1'b0, cnt};

  logic scan_exact;
  logic cur_busy;
  assign cur_busy = page_map[ptr[PW-1:WW]][ptr[WW-1:0]];

  assign sts.alloc      = (op == OP_ALLOC);
  assign sts.fail_early = (cnt == '0) || (cnt > (PW+1)'(PAGES));
  assign sts.win_valid  = wok;
  assign sts.found      = ok && (ptr < w_end) && !cur_busy && (run + 1'b1 == cnt);
  assign sts.scan_done  = (ptr >= w_end) || (ok && scan_exact && cur_busy);
  assign sts.sweep_done = (ptr >= s_end);
  assign sts.span_done  = (ptr == (PW+1)'(PAGES - 1)) || (ptr >= (PW+1)'(PAGES));

  logic chit [CHUNKS];
  always_comb begin
    for (int i = 0; i < CHUNKS; i++) begin
      chit[i] = (chunk_lo((CW+1)'(i)) < chunk_lo((CW+1)'(i + 1))) &&
                (s_start < s_end) && (chunk_lo((CW+1)'(i)) < s_end) &&
                (chunk_lo((CW+1)'(i + 1)) > s_start);
    end
  end

  function automatic logic [10:0] users_dec(input int i);
    logic [10:0] u;
    u = chunk_users[i];
    if (chit[i] && u != 0) u = u - 1'b1;
    return u;
  endfunction

  logic [CHUNKS-1:0] on_a, on_b, on_r;
  logic              walk;
  always_comb begin
    on_a = chunk_on;
    for (int i = 0; i < CHUNKS; i++) if (chit[i]) on_a[i] = 1'b1;
    on_b = on_a;
    for (int i = 0; i < CHUNKS; i++) begin
      logic below, above;
      below = 1'b0; above = 1'b0;
      for (int j = 0; j < CHUNKS; j++) begin
        if (j <= i && on_a[j]) below = 1'b1;
        if (j >= i && on_a[j]) above = 1'b1;
      end
      if (below && above) on_b[i] = 1'b1;
    end
    // Deactivation walks on post-decrement users
    on_r = chunk_on;
    walk = 1'b1;
    for (int i = 0; i < CHUNKS; i++) begin
      if (walk && on_r[i]) begin
        if (users_dec(i) != 0) walk = 1'b0;
        else on_r[i] = 1'b0;
      end
    end
    walk = 1'b1;
    for (int i = CHUNKS - 1; i >= 0; i--) begin
      if (walk && on_r[i]) begin
        if (users_dec(i) != 0) walk = 1'b0;
        else on_r[i] = 1'b0;
      end
    end
  end

  logic              chg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WORDS; i++) page_map[i] <= '0;
      chunk_on   <= '0;
      for (int i = 0; i < CHUNKS; i++) chunk_users[i] <= '0;
      low_used   <= '1;
      high_used  <= '0;
      span_empty <= 1'b1;
      chg        <= 1'b0;
    end else begin
      if (cmd.start) begin
        op        <= req_op;
        cnt       <= req_count;
        rel_start <= req_start;
        chg       <= 1'b0;
      end else if (cmd.chunk && mode) begin
        if (op == OP_ALLOC) begin
          chunk_on <= on_b;
          chg <= (on_b != chunk_on);
          for (int i = 0; i < CHUNKS; i++)
            if (chit[i] && chunk_users[i] < 11'(USERS_MAX))
              chunk_users[i] <= chunk_users[i] + 1'b1;
        end else begin
          chunk_on <= on_r;
          chg <= (on_r != chunk_on);
          for (int i = 0; i < CHUNKS; i++) chunk_users[i] <= users_dec(i);
        end
      end
      // Walker pointer: a new walk takes priority over a step
      if (cmd.scan_start) begin
        ptr <= wlo;
      end else if (cmd.clr_start) begin
        ptr <= (op == OP_ALLOC) ? ptr + 1'b1 - cnt : {1'b0, rel_start};
      end else if (cmd.span_start) begin
        ptr <= '0;
      end else if (cmd.scan || cmd.span || (cmd.mark && ptr < s_end)) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.scan_start) begin
        run        <= '0;
        scan_exact <= wexact;
        if (wexact && wsum > (PW+2)'(PAGES)) begin
          w_end <= wlo;
          ok    <= 1'b0;
        end else begin
          w_end <= wexact ? wsum[PW:0] :
                   ((whi > (PW+1)'(PAGES)) ? (PW+1)'(PAGES) : whi);
          ok    <= 1'b1;
        end
      end else if (cmd.scan) begin
        if (cur_busy) run <= '0;
        else run <= run + 1'b1;
        if (sts.found) found_pos <= ptr + 1'b1 - cnt;
      end
      if (cmd.clr_start) begin
        if (op == OP_ALLOC) begin
          s_start <= ptr + 1'b1 - cnt;
          s_end   <= ptr + 1'b1;
        end else begin
          s_start <= {1'b0, rel_start};
          s_end   <= (rsum > (PW+2)'(PAGES)) ? (PW+1)'(PAGES) : rsum[PW:0];
        end
      end else if (cmd.mark && ptr < s_end) begin
        page_map[ptr[PW-1:WW]][ptr[WW-1:0]] <= (op == OP_ALLOC);
      end
      if (cmd.span_start) begin
        n_empty <= 1'b1;
        n_low <= '1;
        n_high <= '0;
      end else if (cmd.span) begin
        if (cur_busy) begin
          if (n_empty) n_low <= ptr;
          n_empty <= 1'b0;
          n_high <= ptr[PW-1:0];
        end
        if (sts.span_done) begin
          span_empty <= n_empty && !cur_busy;
          low_used   <= (n_empty && cur_busy) ? ptr : n_low;
          high_used  <= cur_busy ? ptr[PW-1:0] : n_high;
        end
      end
    end
  end

  // found flag: remembered when leaving scan via mark path
  logic alloc_ok;
  always_ff @(posedge clk) begin
    if (rst) alloc_ok <= 1'b0;
    else if (cmd.start) alloc_ok <= 1'b0;
    else if (cmd.scan && sts.found) alloc_ok <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      r_status  <= (op == OP_ALLOC) && !alloc_ok;
      r_page    <= (op == OP_ALLOC && alloc_ok) ? found_pos[PW-1:0] : '0;
      r_any     <= any_on;
      r_lo      <= a_lo;
      r_hi      <= a_hi;
      r_changed <= chg;
    end
  end

endmodule

[rtl/core/clustered_page_bitmap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clustered_page_bitmap_allocator
// Page allocator with clustered chunk placement over a 1024-page bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request beat: op, first_page, page_count. m_axis
//   carries one result beat per request. chunked_mode is written through
//   cfg_we/cfg_data; the user must do so only while the block is idle.
//   The block does not enforce this. One request at a time. The bitmap is
//   walked one page a cycle by the single bitmap walker: each search
//   window in turn, then the marking or clearing of the run, then the span
//   recompute over the whole bitmap. A zero or oversize allocate skips the
//   walks and answers once the output register is free.
//   Reset clears the bitmap, chunk state and span at once and sets chunked
//   mode. A result waits in the output register while m_axis_tready is
//   low; a new request may be taken meanwhile, but its result holds until
//   that beat has left.
// ----------------------------------------------------------------------------
module clustered_page_bitmap_allocator
  import cpba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // op, first_page[9:0], page_count[10:0], pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status, page_index, any_active,
                                     // active_low_chunk, active_high_chunk,
                                     // region_changed, pad
);

  cmd_t cmd;
  sts_t sts;
  logic busy, mode, fire;
  logic r_status, r_any, r_changed;
  logic [PW-1:0] r_page;
  logic [CW-1:0] r_lo, r_hi;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b1;
    else if (cfg_we) mode <= cfg_data;
  end

  assign s_axis_tready = !busy;
  assign fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.load_out) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  cpba_ctrl u_ctrl (
    .clk, .rst,
    .in_fire (fire),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .mode, .sts, .cmd, .busy
  );

  cpba_dp u_dp (
    .clk, .rst, .mode,
    .req_op   (s_axis_tdata[0]),
    .req_start(s_axis_tdata[10:1]),
    .req_count(s_axis_tdata[21:11]),
    .cmd, .sts,
    .r_status, .r_page, .r_any, .r_lo, .r_hi, .r_changed
  );

  assign m_axis_tdata = {7'd0, r_changed, r_hi, r_lo, r_any, r_page, r_status};

endmodule
